// ===== hdl/scd_pkg.sv =====
// Shared types, constants and the month table of the seconds-to-calendar converter.
package scd_pkg;

  // Register stages between the request input and the result output.
  localparam int NUM_STAGES = 6;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Calendar constants.
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned JDN_AT_EPOCH  = 2440588;
  localparam int unsigned JDN_SHIFT     = 32044;
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_4Y   = 1461;
  localparam int unsigned DAYS_PER_5M   = 153;

  // Julian day plus the conversion shift, relative to the epoch day count.
  localparam int unsigned A_OFFSET = JDN_AT_EPOCH + JDN_SHIFT;
  // Offset of 4*a + 3 relative to 4 * day count.
  localparam int unsigned B_OFFSET = 4 * A_OFFSET + 3;
  // Over the whole input range the 400-year index b is 67, 68 or 69.
  localparam int unsigned B_FIRST  = 67;
  localparam int unsigned B_THR_1  = (B_FIRST + 1) * DAYS_PER_400Y;
  localparam int unsigned B_THR_2  = (B_FIRST + 2) * DAYS_PER_400Y;
  localparam int unsigned B_CUT_0  = (B_FIRST * DAYS_PER_400Y) / 4;
  localparam int unsigned B_CUT_1  = ((B_FIRST + 1) * DAYS_PER_400Y) / 4;
  localparam int unsigned B_CUT_2  = ((B_FIRST + 2) * DAYS_PER_400Y) / 4;
  // 100 * 67 - 4800: the year at the first value of b.
  localparam int unsigned YEAR_BASE = 100 * B_FIRST - 4800;
  // Julian day of the epoch modulo 7, for the weekday.
  localparam int unsigned WDAY_OFFSET = JDN_AT_EPOCH % 7;

  // Reciprocals for exact division by constants: q = (x * RECIP) >> SHIFT.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // x / 675, x < 2^25
  localparam int          DAY_SHIFT  = 35;
  localparam logic [16:0] WDAY_RECIP = 17'd74899;     // x / 7, x < 2^16
  localparam int          WDAY_SHIFT = 19;
  localparam logic [18:0] Y4_RECIP   = 19'd367469;    // x / 1461, x < 2^18
  localparam int          Y4_SHIFT   = 29;
  localparam logic [11:0] M5_RECIP   = 12'd3427;      // x / 153, x < 2^11
  localparam int          M5_SHIFT   = 19;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // x / 225, x < 2^13
  localparam int          HOUR_SHIFT = 21;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;      // x / 60, x < 2^12
  localparam int          MIN_SHIFT  = 18;

  // Month index at which the year rolls over (March-based months).
  localparam logic [3:0] M_ROLL = 4'd10;

  // Days before the start of a March-based month: (153 * m + 2) / 5.
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== hdl/scd_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the conversion pipeline.
module scd_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scd_pkg::stage_en_t   en
);

  scd_pkg::stage_en_t v_r;
  scd_pkg::stage_en_t v_nxt;
  logic [scd_pkg::NUM_STAGES:0] rdy;
  logic in_acc;
  logic out_acc;

  // A stage may load when it is empty or its content moves on in the same cycle.
  always_comb begin
    rdy[scd_pkg::NUM_STAGES] = out_ready;
    for (int k = scd_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign en = rdy[scd_pkg::NUM_STAGES-1:0];

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < scd_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0] && rst_n;
  assign out_valid = v_r[scd_pkg::NUM_STAGES-1];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // A held stage keeps its request.
  a_hold_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(v_r & ~en) & ~v_r) == '0))
    else $error("stalled pipeline stage lost its request");

  // Requests in flight change only by what enters and what leaves.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) + int'($past(out_acc))
                      == $countones($past(v_r)) + int'($past(in_acc))))
    else $error("request count in the pipeline is not conserved");

  // An empty first stage always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("input refused although the first stage is empty");

endmodule

// ===== hdl/scd_day_split.sv =====
// Splits the seconds count into whole days and seconds of the day.
module scd_day_split (
  input  logic                clk,
  input  scd_pkg::stage_en_t  en,
  input  logic [31:0]         in_epoch_seconds,
  output logic [15:0]         days,
  output logic [16:0]         sec_of_day
);

  logic [31:0] secs_r;
  logic [15:0] days_r;
  logic [15:0] days_nxt;
  logic [50:0] day_prod;
  logic [16:0] sod_r;
  logic [16:0] sod_nxt;

  // 86400 = 128 * 675: drop the low seven bits, then divide by 675.
  assign day_prod = 51'(in_epoch_seconds[31:7]) * 51'(scd_pkg::DAY_RECIP);
  assign days_nxt = day_prod[scd_pkg::DAY_SHIFT +: 16];

  assign sod_nxt = 17'(secs_r - (32'(days_r) * 32'(scd_pkg::SECS_PER_DAY)));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      secs_r <= in_epoch_seconds;
      days_r <= days_nxt;
    end
    if (en[1]) begin
      sod_r <= sod_nxt;
    end
  end

  assign days       = days_r;
  assign sec_of_day = sod_r;

endmodule

// ===== hdl/scd_tod_path.sv =====
// Hours, minutes and seconds from the seconds of the day.
module scd_tod_path (
  input  logic                clk,
  input  scd_pkg::stage_en_t  en,
  input  logic [16:0]         sec_of_day,
  output logic [4:0]          hours,
  output logic [5:0]          minutes,
  output logic [5:0]          seconds
);

  logic [26:0] hour_prod;
  logic [4:0]  hours3_r;
  logic [16:0] sod3_r;
  logic [11:0] soh_nxt;
  logic [11:0] soh4_r;
  logic [4:0]  hours4_r;
  logic [24:0] min_prod;
  logic [5:0]  min5_r;
  logic [11:0] soh5_r;
  logic [4:0]  hours5_r;
  logic [5:0]  sec_nxt;
  logic [4:0]  hours_r;
  logic [5:0]  minutes_r;
  logic [5:0]  seconds_r;

  // 3600 = 16 * 225.
  assign hour_prod = 27'(sec_of_day[16:4]) * 27'(scd_pkg::HOUR_RECIP);
  assign soh_nxt   = 12'(sod3_r - 17'(17'(hours3_r) * 17'(scd_pkg::SECS_PER_HOUR)));
  assign min_prod  = 25'(soh4_r) * 25'(scd_pkg::MIN_RECIP);
  assign sec_nxt   = 6'(soh5_r - 12'(12'(min5_r) * 12'(scd_pkg::SECS_PER_MIN)));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hours3_r <= hour_prod[scd_pkg::HOUR_SHIFT +: 5];
      sod3_r   <= sec_of_day;
    end
    if (en[3]) begin
      soh4_r   <= soh_nxt;
      hours4_r <= hours3_r;
    end
    if (en[4]) begin
      min5_r   <= min_prod[scd_pkg::MIN_SHIFT +: 6];
      soh5_r   <= soh4_r;
      hours5_r <= hours4_r;
    end
    if (en[5]) begin
      hours_r   <= hours5_r;
      minutes_r <= min5_r;
      seconds_r <= sec_nxt;
    end
  end

  assign hours   = hours_r;
  assign minutes = minutes_r;
  assign seconds = seconds_r;

endmodule

// ===== hdl/scd_date_path.sv =====
// Julian-day-to-Gregorian conversion and weekday from the day count.
module scd_date_path (
  input  logic                clk,
  input  scd_pkg::stage_en_t  en,
  input  logic [15:0]         days,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day_of_month,
  output logic [2:0]          weekday
);

  // Stage 2: 400-year index, day within the 400-year cycle, weekday quotient.
  logic [23:0] b_num;
  logic [1:0]  bsel_nxt;
  logic [21:0] a_val;
  logic [21:0] b_cut;
  logic [15:0] dp3;
  logic [32:0] wday_prod;
  logic [1:0]  bsel2_r;
  logic [15:0] c2_r;
  logic [15:0] dp3_r;
  logic [12:0] q7_r;

  // Stage 3 and on.
  logic [17:0] c_num;
  logic [36:0] y4_prod;
  logic [2:0]  wday_nxt;
  logic [1:0]  bsel3_r;
  logic [15:0] c3_r;
  logic [6:0]  d3_r;
  logic [2:0]  wday3_r;
  logic [8:0]  e_nxt;
  logic [1:0]  bsel4_r;
  logic [6:0]  d4_r;
  logic [8:0]  e4_r;
  logic [2:0]  wday4_r;
  logic [22:0] m5_prod;
  logic [10:0] m_num;
  logic [1:0]  bsel5_r;
  logic [6:0]  d5_r;
  logic [8:0]  e5_r;
  logic [3:0]  m5_r;
  logic [2:0]  wday5_r;
  logic        roll;
  logic [11:0] year_nxt;
  logic [3:0]  month_nxt;
  logic [8:0]  mday_nxt;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  mday_r;
  logic [2:0]  wday_r;

  // b can only be 67, 68 or 69, so two compares replace the division.
  assign b_num = {days, 2'b00} + 24'(scd_pkg::B_OFFSET);
  assign a_val = 22'(days) + 22'(scd_pkg::A_OFFSET);

  always_comb begin
    priority if (b_num >= 24'(scd_pkg::B_THR_2)) begin
      bsel_nxt = 2'd2;
      b_cut    = 22'(scd_pkg::B_CUT_2);
    end else if (b_num >= 24'(scd_pkg::B_THR_1)) begin
      bsel_nxt = 2'd1;
      b_cut    = 22'(scd_pkg::B_CUT_1);
    end else begin
      bsel_nxt = 2'd0;
      b_cut    = 22'(scd_pkg::B_CUT_0);
    end
  end

  assign dp3       = days + 16'(scd_pkg::WDAY_OFFSET);
  assign wday_prod = 33'(dp3) * 33'(scd_pkg::WDAY_RECIP);

  assign c_num    = {c2_r, 2'b11};
  assign y4_prod  = 37'(c_num) * 37'(scd_pkg::Y4_RECIP);
  assign wday_nxt = 3'(dp3_r - 16'(16'(q7_r) * 16'd7));

  assign e_nxt = 9'(c3_r - 16'((18'(d3_r) * 18'(scd_pkg::DAYS_PER_4Y)) >> 2));

  assign m_num   = 11'(e4_r) * 11'd5 + 11'd2;
  assign m5_prod = 23'(m_num) * 23'(scd_pkg::M5_RECIP);

  // Months run from March; January and February belong to the next year.
  assign roll      = (m5_r >= scd_pkg::M_ROLL);
  assign month_nxt = roll ? 4'(m5_r - 4'd9) : 4'(m5_r + 4'd3);
  assign year_nxt  = 12'(scd_pkg::YEAR_BASE) + 12'(bsel5_r) * 12'd100
                     + 12'(d5_r) + 12'(roll);
  assign mday_nxt  = e5_r - scd_pkg::month_base(m5_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bsel2_r <= bsel_nxt;
      c2_r    <= 16'(a_val - b_cut);
      dp3_r   <= dp3;
      q7_r    <= wday_prod[scd_pkg::WDAY_SHIFT +: 13];
    end
    if (en[2]) begin
      bsel3_r <= bsel2_r;
      c3_r    <= c2_r;
      d3_r    <= y4_prod[scd_pkg::Y4_SHIFT +: 7];
      wday3_r <= wday_nxt;
    end
    if (en[3]) begin
      bsel4_r <= bsel3_r;
      d4_r    <= d3_r;
      e4_r    <= e_nxt;
      wday4_r <= wday3_r;
    end
    if (en[4]) begin
      bsel5_r <= bsel4_r;
      d5_r    <= d4_r;
      e5_r    <= e4_r;
      m5_r    <= m5_prod[scd_pkg::M5_SHIFT +: 4];
      wday5_r <= wday4_r;
    end
    if (en[5]) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      mday_r  <= mday_nxt[4:0];
      wday_r  <= wday5_r;
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = mday_r;
  assign weekday      = wday_r;

endmodule

// ===== hdl/seconds_to_calendar_date_unit.sv =====
// Top level of the seconds-to-calendar-date converter.
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, the time of day and the weekday (0 is Monday). Every input value is
// valid. The converter is a six-stage pipeline: a request is loaded into the first stage
// at the edge that accepts it, and its result moves stage by stage into the output
// registers; one request can be taken in every cycle while the output is not stalled.
// Each stage holds at most one request and loads whenever it is empty or its content
// moves on, so ready follows stage occupancy and gaps are squeezed out while the output
// is stalled. The stage depth is set by the constant-reciprocal multiplications.
module seconds_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [2:0]  out_weekday
);

  scd_pkg::stage_en_t en;
  logic [15:0] days;
  logic [16:0] sec_of_day;

  scd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  scd_day_split u_split (
    .clk              (clk),
    .en               (en),
    .in_epoch_seconds (in_epoch_seconds),
    .days             (days),
    .sec_of_day       (sec_of_day)
  );

  scd_tod_path u_tod (
    .clk        (clk),
    .en         (en),
    .sec_of_day (sec_of_day),
    .hours      (out_hours),
    .minutes    (out_minutes),
    .seconds    (out_seconds)
  );

  scd_date_path u_date (
    .clk          (clk),
    .en           (en),
    .days         (days),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month),
    .weekday      (out_weekday)
  );

  // Every delivered result is a real calendar date and time.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month != 5'd0
                   && out_hours <= 5'd23 && out_minutes <= 6'd59
                   && out_seconds <= 6'd59 && out_weekday <= 3'd6))
    else $error("result field out of calendar range");

endmodule
